### rtl/gsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_pkg - shared types and constants of the gravity-axis shake detector
// Datapath widths, sequencer step codes, register indexes, direction codes.
// ----------------------------------------------------------------------------
package gsd_pkg;

  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 16;
  localparam int LO_W       = 16;
  localparam int NUM_W      = 35;
  localparam int N2_W       = 32;
  localparam int MAG_W      = 32;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int THR2_W     = 30;
  localparam int RHS_W      = 62;
  localparam int HALF_W     = 4;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef logic [STEP_W-1:0] step_t;

  // one multiplier issue per step; each product is registered before it is consumed
  localparam step_t STEP_GLO0  = 5'd0;
  localparam step_t STEP_GHI0  = 5'd1;
  localparam step_t STEP_GLO1  = 5'd2;
  localparam step_t STEP_GHI1  = 5'd3;
  localparam step_t STEP_GLO2  = 5'd4;
  localparam step_t STEP_GHI2  = 5'd5;
  localparam step_t STEP_PDG0  = 5'd6;
  localparam step_t STEP_PGG0  = 5'd7;
  localparam step_t STEP_PDG1  = 5'd8;
  localparam step_t STEP_PGG1  = 5'd9;
  localparam step_t STEP_PDG2  = 5'd10;
  localparam step_t STEP_PGG2  = 5'd11;
  localparam step_t STEP_MING  = 5'd12;
  localparam step_t STEP_THR2  = 5'd13;
  localparam step_t STEP_THRN  = 5'd14;
  localparam step_t STEP_NUMSQ = 5'd15;
  localparam step_t STEP_CMP   = 5'd16;

  typedef logic [1:0] axis_t;
  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  typedef logic signed [1:0] dir_t;
  localparam dir_t DIR_NONE = 2'b00;
  localparam dir_t DIR_UP   = 2'b01;
  localparam dir_t DIR_DOWN = 2'b11;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_FILTER_GAIN     = 3'd0;
  localparam cfg_idx_t CFG_SWING_THRESHOLD = 3'd1;
  localparam cfg_idx_t CFG_MIN_GRAVITY     = 3'd2;
  localparam cfg_idx_t CFG_HALVES_NEEDED   = 3'd3;
  localparam cfg_idx_t CFG_WINDOW_MS       = 3'd4;
  localparam cfg_idx_t CFG_COOLDOWN_MS     = 3'd5;

  localparam logic [15:0] GAIN_RST   = 16'd3277;
  localparam logic [14:0] THR_RST    = 15'd4915;
  localparam logic [14:0] MING_RST   = 15'd1229;
  localparam logic [3:0]  NEEDED_RST = 4'd3;
  localparam logic [15:0] WIN_RST    = 16'd900;
  localparam logic [15:0] COOL_RST   = 16'd2000;

  localparam logic [HALF_W-1:0] HALF_MAX = 4'd15;

endpackage
`default_nettype wire

### rtl/gsd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsd_mul - shared signed multiplier
// 33 x 33 signed multiply with a registered 66-bit product.
// ----------------------------------------------------------------------------
module gsd_mul (
  input  logic                               clk,
  input  logic signed [gsd_pkg::MUL_W-1:0]   a,
  input  logic signed [gsd_pkg::MUL_W-1:0]   b,
  output logic signed [gsd_pkg::PROD_W-1:0]  p
);
  import gsd_pkg::*;

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

### rtl/gravity_axis_shake_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gravity_axis_shake_detector_core - gravity-projected shake detector
// Low-pass gravity per axis, projection of the dynamic part onto gravity,
// up/down classing by squared compares, half-swing counting with window
// and cooldown. All products run through one shared multiplier.
//
//   channel  | handshake                  | beat
//   sample   | sample_valid/sample_stall  | accel_x, accel_y, accel_z, time_ms
//   result   | result_valid/result_stall  | shake, half_count, direction, axis_ok
//   config   | cfg_wr_en                  | cfg_index, cfg_data
//
// Each sample runs through 17 sequencer steps issuing 16 products on the
// single 33x33 multiplier, then the decision/load of the result register;
// no new sample is accepted until that result has been loaded.
// Reset loads default register values; the first sample seeds gravity.
// A result stalled downstream holds the block in its decision step.
// ----------------------------------------------------------------------------
module gravity_axis_shake_detector_core #(
  parameter int EXTRA_FRAC_BITS = 16,
  parameter int TIME_BITS       = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [15:0]                   accel_x,
  input  logic signed [15:0]                   accel_y,
  input  logic signed [15:0]                   accel_z,
  input  logic [31:0]                          time_ms,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic                                 shake,
  output logic [3:0]                           half_count,
  output logic signed [1:0]                    direction,
  output logic                                 axis_ok,
  input  logic                                 cfg_wr_en,
  input  logic [gsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [gsd_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import gsd_pkg::*;

  localparam int GW   = ACC_W + EXTRA_FRAC_BITS;
  localparam int DW   = GW + 1;
  localparam int SUMW = GW + 2;

  state_t                    state, state_next;
  step_t                     step;
  logic                      accept, load_out;

  logic [15:0]               gain;
  logic [14:0]               thr;
  logic [14:0]               ming;
  logic [3:0]                needed;
  logic [15:0]               win;
  logic [15:0]               cool;

  logic signed [ACC_W-1:0]   acc [3];
  logic signed [GW-1:0]      grav [3];
  logic [TIME_BITS-1:0]      tnow;
  logic                      primed;

  logic signed [MUL_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0]  prod;
  step_t                     ptag;
  logic                      pvld;

  axis_t                     ax_i;
  logic signed [ACC_W-1:0]   a_i;
  logic signed [GW-1:0]      g_i;
  logic signed [GW-1:0]      a_fix;
  logic signed [DW-1:0]      diff;
  logic signed [ACC_W-1:0]   gr_i;
  logic signed [ACC_W:0]     dyn;

  axis_t                     ax_w;
  logic signed [GW-1:0]      g_w;
  logic signed [GW:0]        hi_term;
  logic [SUMW-1:0]           g_sum;
  logic signed [GW-1:0]      g_new;

  logic [LO_W-1:0]           lo_term;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          mag_full;
  logic [N2_W-1:0]           n2;
  logic [MAG_W-1:0]          mag;
  logic                      big;
  logic [RHS_W-1:0]          rhs;
  logic                      ok;
  logic                      exc;

  logic [HALF_W-1:0]         halves, halves_next;
  dir_t                      last_dir, last_dir_next;
  logic [TIME_BITS-1:0]      win_start, win_start_next;
  logic [TIME_BITS-1:0]      last_fire, last_fire_next;
  logic [TIME_BITS-1:0]      win_age, fire_age;
  dir_t                      dir_out;
  logic                      fire;

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (step == STEP_CMP) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: sample_stall = 1'b0;
      ST_DONE: load_out = !result_valid || !result_stall;
      default: ;
    endcase
  end

  assign accept = sample_valid && !sample_stall;

  // ---------------- operand select ----------------
  always_comb begin
    if (step < STEP_PDG0) begin
      ax_i = axis_t'(step >> 1);
    end else begin
      ax_i = axis_t'((step - STEP_PDG0) >> 1);
    end
    case (ax_i)
      AX_Y: begin
        a_i = acc[1];
        g_i = grav[1];
      end
      AX_Z: begin
        a_i = acc[2];
        g_i = grav[2];
      end
      default: begin
        a_i = acc[0];
        g_i = grav[0];
      end
    endcase
  end

  assign a_fix    = {a_i, {EXTRA_FRAC_BITS{1'b0}}};
  assign diff     = DW'(a_fix) - DW'(g_i);
  assign gr_i     = g_i[GW-1:EXTRA_FRAC_BITS];
  assign dyn      = (ACC_W + 1)'(a_i) - (ACC_W + 1)'(gr_i);
  assign mag_full = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      STEP_GLO0, STEP_GLO1, STEP_GLO2: begin
        op_a = MUL_W'(gain);
        op_b = MUL_W'(diff[LO_W-1:0]);
      end
      STEP_GHI0, STEP_GHI1, STEP_GHI2: begin
        op_a = MUL_W'(gain);
        op_b = MUL_W'($signed(diff[DW-1:LO_W]));
      end
      STEP_PDG0, STEP_PDG1, STEP_PDG2: begin
        op_a = MUL_W'(dyn);
        op_b = MUL_W'(gr_i);
      end
      STEP_PGG0, STEP_PGG1, STEP_PGG2: begin
        op_a = MUL_W'(gr_i);
        op_b = MUL_W'(gr_i);
      end
      STEP_MING: begin
        op_a = MUL_W'(ming);
        op_b = MUL_W'(ming);
      end
      STEP_THR2: begin
        op_a = MUL_W'(thr);
        op_b = MUL_W'(thr);
      end
      STEP_THRN: begin
        op_a = MUL_W'(prod[THR2_W-1:0]);
        op_b = MUL_W'(n2);
      end
      STEP_NUMSQ: begin
        op_a = MUL_W'(mag);
        op_b = MUL_W'(mag);
      end
      default: ;
    endcase
  end

  gsd_mul u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  // ---------------- gravity write-back ----------------
  always_comb begin
    ax_w = axis_t'(ptag >> 1);
    case (ax_w)
      AX_Y:    g_w = grav[1];
      AX_Z:    g_w = grav[2];
      default: g_w = grav[0];
    endcase
  end

  assign hi_term = prod[GW:0];
  assign g_sum   = SUMW'(g_w) + SUMW'(hi_term) + SUMW'(lo_term);
  assign g_new   = g_sum[GW-1:0];

  // ---------------- decision ----------------
  assign win_age  = tnow - win_start;
  assign fire_age = tnow - last_fire;

  always_comb begin
    dir_out        = DIR_NONE;
    halves_next    = halves;
    last_dir_next  = last_dir;
    win_start_next = win_start;
    last_fire_next = last_fire;
    fire           = 1'b0;
    if (ok) begin
      if (num != '0 && exc) dir_out = num[NUM_W-1] ? DIR_DOWN : DIR_UP;
      if (halves != '0 && win_age > TIME_BITS'(win)) begin
        halves_next   = '0;
        last_dir_next = DIR_NONE;
      end
      if (dir_out != DIR_NONE && dir_out != last_dir_next) begin
        if (halves_next == '0) win_start_next = tnow;
        if (halves_next != HALF_MAX) halves_next = halves_next + HALF_W'(1);
        last_dir_next = dir_out;
        if (halves_next >= needed && fire_age > TIME_BITS'(cool)) begin
          last_fire_next = tnow;
          halves_next    = '0;
          last_dir_next  = DIR_NONE;
          fire           = 1'b1;
        end
      end
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= '0;
      pvld         <= 1'b0;
      primed       <= 1'b0;
      result_valid <= 1'b0;
      halves       <= '0;
      last_dir     <= DIR_NONE;
      win_start    <= '0;
      last_fire    <= '0;
      gain         <= GAIN_RST;
      thr          <= THR_RST;
      ming         <= MING_RST;
      needed       <= NEEDED_RST;
      win          <= WIN_RST;
      cool         <= COOL_RST;
    end else begin
      state <= state_next;
      pvld  <= (state == ST_CALC);
      if (accept) begin
        step   <= '0;
        primed <= 1'b1;
      end else if (state == ST_CALC) begin
        step <= step + STEP_W'(1);
      end
      if (load_out) begin
        result_valid <= 1'b1;
        halves       <= halves_next;
        last_dir     <= last_dir_next;
        win_start    <= win_start_next;
        last_fire    <= last_fire_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FILTER_GAIN:     gain   <= cfg_data;
          CFG_SWING_THRESHOLD: thr    <= cfg_data[14:0];
          CFG_MIN_GRAVITY:     ming   <= cfg_data[14:0];
          CFG_HALVES_NEEDED:   needed <= cfg_data[3:0];
          CFG_WINDOW_MS:       win    <= cfg_data;
          CFG_COOLDOWN_MS:     cool   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    ptag <= step;
    if (accept) begin
      acc[0] <= accel_x;
      acc[1] <= accel_y;
      acc[2] <= accel_z;
      tnow   <= TIME_BITS'(time_ms);
      num    <= '0;
      n2     <= '0;
      if (!primed) begin
        grav[0] <= {accel_x, {EXTRA_FRAC_BITS{1'b0}}};
        grav[1] <= {accel_y, {EXTRA_FRAC_BITS{1'b0}}};
        grav[2] <= {accel_z, {EXTRA_FRAC_BITS{1'b0}}};
      end
    end
    if (state == ST_CALC && step == STEP_THRN) begin
      mag <= mag_full[MAG_W-1:0];
      big <= |mag_full[NUM_W-1:MAG_W];
    end
    if (pvld) begin
      case (ptag)
        STEP_GLO0, STEP_GLO1, STEP_GLO2: lo_term <= prod[2*LO_W-1:LO_W];
        STEP_GHI0, STEP_GHI1, STEP_GHI2: begin
          case (ax_w)
            AX_Y:    grav[1] <= g_new;
            AX_Z:    grav[2] <= g_new;
            default: grav[0] <= g_new;
          endcase
        end
        STEP_PDG0, STEP_PDG1, STEP_PDG2: num <= num + $signed(prod[NUM_W-1:0]);
        STEP_PGG0, STEP_PGG1, STEP_PGG2: n2 <= n2 + prod[N2_W-1:0];
        STEP_MING:  ok  <= n2 > prod[N2_W-1:0];
        STEP_THRN:  rhs <= prod[RHS_W-1:0];
        STEP_NUMSQ: exc <= big || (prod[SQ_W-1:0] > SQ_W'(rhs));
        default: ;
      endcase
    end
    if (load_out) begin
      shake      <= fire;
      half_count <= halves_next;
      direction  <= dir_out;
      axis_ok    <= ok;
    end
  end

  // ---------------- assertions ----------------
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside the decision step");

  a_dir_needs_gravity: assert property (@(posedge clk) disable iff (rst)
    (result_valid && direction != DIR_NONE) |-> axis_ok)
    else $error("direction reported with weak gravity");

  a_shake_clears_count: assert property (@(posedge clk) disable iff (rst)
    (result_valid && shake) |-> (half_count == '0))
    else $error("shake beat with nonzero half count");

  a_primed_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> primed)
    else $error("gravity not seeded after first sample");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) |-> (step <= STEP_CMP))
    else $error("sequencer step out of range");

endmodule
`default_nettype wire
